// ===== rtl/core/ssba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Sizes, status codes and arithmetic helpers shared by the allocator files.
// ----------------------------------------------------------------------------
package ssba_pkg;

  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  localparam int SECTOR_W = 13;
  localparam int COUNT_W  = 11;

  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int LIM_W     = $clog2(WORD_W + 1);
  localparam int NUM_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam int ACT_W = ($clog2(MAX_SLOTS + 1) > COUNT_W) ? $clog2(MAX_SLOTS + 1) : COUNT_W;
  localparam int QUO_W = ((ROW_W + BIT_W) > SECTOR_W) ? (ROW_W + BIT_W) : SECTOR_W;
  localparam int CMP_W = (QUO_W > ACT_W) ? QUO_W : ACT_W;

  localparam int DIV_SHIFT  = SECTOR_W + $clog2(SECTORS_PER_SLOT);
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + SECTORS_PER_SLOT - 1) / SECTORS_PER_SLOT;
  localparam int DIV_PROD_W = SECTOR_W + DIV_SHIFT + 1;
  localparam int SEC_PROD_W = ACT_W + 7;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Exact quotient by a reciprocal multiply for any sector value.
  function automatic logic [QUO_W-1:0] sector_to_slot(input logic [SECTOR_W-1:0] sector);
    logic [DIV_PROD_W-1:0] prod;
    prod = DIV_PROD_W'(sector) * DIV_PROD_W'(DIV_MULT);
    return QUO_W'(prod >> DIV_SHIFT);
  endfunction

  function automatic logic [BIT_W-1:0] first_free(input logic [WORD_W-1:0] free);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/ssba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate or release command word.
// ----------------------------------------------------------------------------
interface ssba_req_if import ssba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic                has_old;
  logic [SECTOR_W-1:0] old_sector;

  modport source (output valid, command, has_old, old_sector, input ready);
  modport sink   (input valid, command, has_old, old_sector, output ready);
endinterface

// ===== rtl/core/ssba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one status and sector result word.
// ----------------------------------------------------------------------------
interface ssba_rsp_if import ssba_pkg::*; ();
  logic                valid;
  logic                ready;
  status_e             status;
  logic [SECTOR_W-1:0] alloc_sector;

  modport source (output valid, status, alloc_sector, input ready);
  modport sink   (input valid, status, alloc_sector, output ready);
endinterface

// ===== rtl/core/ssba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssba_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/swap_slot_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator
// First-fit allocator over a used/free bitmap held in a 64-bit wide RAM.
// ----------------------------------------------------------------------------
// The bitmap sits in a RAM of 64-bit rows, each row marked invalid at reset so
// that all slots read free with no clearing pass. A release passes through the
// old-slot read state to the response state, and through the old-slot write
// state as well only when it names a slot in range. An allocate scans one row
// per cycle through the RAM read port, reading at most ceil(active slots / 64)
// rows, then frees its old slot the same way as a release; when it finds no
// free slot it goes straight to the response state, freeing nothing.
// One command is processed at a time; the request channel is ready again from
// the cycle in which the result enters the output register, and a result still
// waiting there holds back the next one.
module swap_slot_bitmap_allocator import ssba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ssba_req_if.sink           req_i,
  ssba_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_OLD_RD = 5'b00100,
    S_OLD_WR = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [COUNT_W-1:0]  slot_count_q;
  logic                cmd_q, cmd_d;
  logic                has_old_q, has_old_d;
  logic [QUO_W-1:0]    old_slot_q, old_slot_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ROW_W-1:0]    rd_addr_q;
  status_e             res_status_q, res_status_d;
  logic [SECTOR_W-1:0] res_sector_q, res_sector_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [SECTOR_W-1:0] out_sector_q;
  logic [NUM_WORDS-1:0] row_valid_q;

  logic                mem_we, mem_re;
  logic [ROW_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata;

  logic [ACT_W-1:0]    n_act, row_base, remaining, found_slot;
  logic [LIM_W-1:0]    lim;
  logic [WORD_W-1:0]   word, avail, free_bits;
  logic [BIT_W-1:0]    free_idx;
  logic                old_in_range, accept, out_load;

  ssba_ram #(
    .Width(WORD_W),
    .Depth(NUM_WORDS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign n_act = (ACT_W'(slot_count_q) < ACT_W'(MAX_SLOTS)) ? ACT_W'(slot_count_q)
                                                            : ACT_W'(MAX_SLOTS);
  assign row_base  = ACT_W'({row_q, BIT_W'(0)});
  assign remaining = n_act - row_base;
  assign lim       = (remaining >= ACT_W'(WORD_W)) ? LIM_W'(WORD_W) : LIM_W'(remaining);
  assign avail     = ~({WORD_W{1'b1}} << lim);
  assign word      = row_valid_q[rd_addr_q] ? mem_rdata : '0;
  assign free_bits = ~word & avail;
  assign free_idx  = first_free(free_bits);
  assign found_slot = row_base + ACT_W'(free_idx);
  assign old_in_range = CMP_W'(old_slot_q) < CMP_W'(n_act);

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.alloc_sector = out_sector_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    has_old_d    = has_old_q;
    old_slot_d   = old_slot_q;
    row_d        = row_q;
    res_status_d = res_status_q;
    res_sector_d = res_sector_q;
    mem_we       = 1'b0;
    mem_waddr    = row_q;
    mem_wdata    = word | (WORD_W'(1) << free_idx);
    mem_re       = 1'b0;
    mem_raddr    = row_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d        = req_i.command;
          has_old_d    = req_i.has_old;
          old_slot_d   = sector_to_slot(req_i.old_sector);
          res_status_d = ST_DONE;
          res_sector_d = '0;
          row_d        = '0;
          if (req_i.command) begin
            state_d = S_OLD_RD;
          end else if (n_act != '0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_d   = S_SCAN;
          end else begin
            res_status_d = ST_FULL;
            state_d      = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          mem_we       = 1'b1;
          res_sector_d = SECTOR_W'(SEC_PROD_W'(found_slot) * SEC_PROD_W'(SECTORS_PER_SLOT));
          state_d      = S_OLD_RD;
        end else if ((row_base + ACT_W'(WORD_W)) < n_act) begin
          row_d     = row_q + ROW_W'(1);
          mem_re    = 1'b1;
          mem_raddr = row_q + ROW_W'(1);
        end else begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end
      end
      S_OLD_RD: begin
        if (has_old_q && old_in_range) begin
          mem_re    = 1'b1;
          mem_raddr = old_slot_q[BIT_W +: ROW_W];
          state_d   = S_OLD_WR;
        end else begin
          res_status_d = has_old_q ? ST_RANGE : ST_DONE;
          state_d      = S_RESP;
        end
      end
      S_OLD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = old_slot_q[BIT_W +: ROW_W];
        mem_wdata = word & ~(WORD_W'(1) << old_slot_q[BIT_W-1:0]);
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_count_q <= '0;
      out_valid_q  <= 1'b0;
      row_valid_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        row_valid_q[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    has_old_q    <= has_old_d;
    old_slot_q   <= old_slot_d;
    row_q        <= row_d;
    res_status_q <= res_status_d;
    res_sector_q <= res_sector_d;
    if (mem_re) begin
      rd_addr_q <= mem_raddr;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_sector_q <= res_sector_q;
    end
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (row_base < n_act))
    else $error("Scan row lies beyond the active slots.");

  a_alloc_sets_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_we) |-> $onehot(mem_wdata ^ word))
    else $error("Allocation did not mark exactly one free slot.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("A new word was taken while a command was in progress.");

  a_release_only_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !cmd_q)
    else $error("A release command entered the allocation scan.");
`endif

endmodule

// ===== verif/tb_swap_slot_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swap slot bitmap allocator testbench
// Sends allocate and release words through a bursty request channel. Result
// words are taken through a stalling response channel and checked in order
// against a bit-level model of the slot bitmap and the slot count register.
// ----------------------------------------------------------------------------
module tb_swap_slot_bitmap_allocator;
  import ssba_pkg::*;

  localparam logic CMD_ALLOC    = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int NUM_ROWS       = 26;
  localparam int NUM_PHASES     = 9;
  localparam int GAPLESS_PHASE  = 3;
  localparam int PAUSE_PHASE    = 6;
  localparam int PAUSE_AT       = 40;

  typedef struct packed {
    status_e             status;
    logic [SECTOR_W-1:0] alloc_sector;
  } rsp_word_t;

  typedef struct {
    bit                  is_cfg;
    logic [COUNT_W-1:0]  cfg_value;
    logic                command;
    logic                has_old;
    logic [SECTOR_W-1:0] old_sector;
    bit                  fixed;
    status_e             status;
    logic [SECTOR_W-1:0] alloc_sector;
  } dir_row_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  ssba_req_if req_if ();
  ssba_rsp_if rsp_if ();

  swap_slot_bitmap_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  logic [MAX_SLOTS-1:0] slot_map;
  logic [COUNT_W-1:0]   slot_count_q;
  rsp_word_t            pending_results [$];
  dir_row_t             dir_rows [NUM_ROWS];

  int phase_count [NUM_PHASES] = '{0, 1, 2, 64, 65, 1024, 300, 2047, -1};
  int phase_items [NUM_PHASES] = '{20, 30, 30, 60, 60, 600, 80, 60, 60};
  int phase_alloc [NUM_PHASES] = '{50, 60, 60, 60, 60, 97, 40, 55, 55};
  int phase_old   [NUM_PHASES] = '{50, 50, 50, 50, 50, 5, 70, 50, 50};

  int       errors;
  int       stall_cycles;
  int       hold_requests;
  int       holds_served;
  int       hold_left;
  int       mode_left;
  rx_mode_e rx_mode;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int active_slots();
    return (int'(slot_count_q) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_q);
  endfunction

  function automatic bit free_old_slot(input logic [SECTOR_W-1:0] sector);
    int old_slot;
    old_slot = int'(sector) / SECTORS_PER_SLOT;
    if (old_slot >= active_slots()) begin
      return 1'b0;
    end
    slot_map[old_slot] = 1'b0;
    return 1'b1;
  endfunction

  function automatic rsp_word_t predict_slot_result(input logic cmd, input logic has_old,
                                                    input logic [SECTOR_W-1:0] sector);
    rsp_word_t r;
    int        n;
    int        slot;
    bit        found;
    n = active_slots();
    r.status = ST_DONE;
    r.alloc_sector = '0;
    if (cmd == CMD_ALLOC) begin
      found = 1'b0;
      slot = 0;
      while (!found && slot < n) begin
        if (!slot_map[slot]) begin
          found = 1'b1;
        end else begin
          slot++;
        end
      end
      if (!found) begin
        r.status = ST_FULL;
      end else begin
        slot_map[slot] = 1'b1;
        if (has_old && !free_old_slot(sector)) begin
          r.status = ST_RANGE;
        end
        r.alloc_sector = SECTOR_W'(slot * SECTORS_PER_SLOT);
      end
    end else if (has_old && !free_old_slot(sector)) begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  task automatic send_word(input logic cmd, input logic has_old,
                           input logic [SECTOR_W-1:0] sector, input bit fixed,
                           input rsp_word_t fixed_rsp);
    rsp_word_t want;
    @(negedge clk_i);
    req_if.valid      = 1'b1;
    req_if.command    = cmd;
    req_if.has_old    = has_old;
    req_if.old_sector = sector;
    do @(posedge clk_i); while (!req_if.ready);
    want = predict_slot_result(cmd, has_old, sector);
    if (fixed) begin
      want = fixed_rsp;
    end
    pending_results.push_back(want);
  endtask

  task automatic sender_idle(input int n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    slot_count_q = value;
  endtask

  task automatic make_random_word(input int alloc_pct, input int old_pct, output logic cmd,
                                  output logic has_old, output logic [SECTOR_W-1:0] sector);
    int n;
    n = active_slots();
    cmd = ($urandom_range(99, 0) < alloc_pct) ? CMD_ALLOC : CMD_RELEASE;
    has_old = ($urandom_range(99, 0) < old_pct);
    if (n > 0 && $urandom_range(9, 0) < 7) begin
      sector = SECTOR_W'($urandom_range(n - 1, 0) * SECTORS_PER_SLOT
                         + $urandom_range(SECTORS_PER_SLOT - 1, 0));
    end else begin
      sector = SECTOR_W'($urandom());
    end
  endtask

  initial begin
    logic                cmd;
    logic                has_old;
    logic [SECTOR_W-1:0] sector;
    int                  burst;
    int                  sent;
    req_if.valid      = 1'b0;
    req_if.command    = CMD_ALLOC;
    req_if.has_old    = 1'b0;
    req_if.old_sector = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    slot_map          = '0;
    slot_count_q      = '0;
    errors            = 0;
    hold_requests     = 0;
    rst_ni            = 1'b0;

    dir_rows = '{
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b0, 13'd0,    1'b1, ST_FULL,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd0,    1'b1, ST_RANGE, 13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b0, 13'd8191, 1'b1, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd8191, 1'b1, ST_FULL,  13'd0},
      '{1'b1, 11'd1,    CMD_ALLOC,   1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b0, 13'd0,    1'b1, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b0, 13'd0,    1'b1, ST_FULL,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd0,    1'b1, ST_FULL,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd7,    1'b1, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd0,    1'b1, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd8,    1'b1, ST_RANGE, 13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd8191, 1'b1, ST_RANGE, 13'd0},
      '{1'b1, 11'd2047, CMD_ALLOC,   1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd8191, 1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd8,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd8191, 1'b0, ST_DONE,  13'd0},
      '{1'b1, 11'd1024, CMD_ALLOC,   1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd8191, 1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b1, 11'd1023, CMD_ALLOC,   1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd8184, 1'b1, ST_RANGE, 13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b1, 13'd8191, 1'b0, ST_DONE,  13'd0},
      '{1'b1, 11'd0,    CMD_ALLOC,   1'b0, 13'd0,    1'b0, ST_DONE,  13'd0},
      '{1'b0, 11'd0,    CMD_ALLOC,   1'b0, 13'd8191, 1'b1, ST_FULL,  13'd0},
      '{1'b0, 11'd0,    CMD_RELEASE, 1'b1, 13'd8191, 1'b1, ST_RANGE, 13'd0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_slot_count(dir_rows[i].cfg_value);
      end else begin
        send_word(dir_rows[i].command, dir_rows[i].has_old, dir_rows[i].old_sector,
                  dir_rows[i].fixed, '{dir_rows[i].status, dir_rows[i].alloc_sector});
        sender_idle($urandom_range(2, 0));
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_slot_count((phase_count[p] < 0) ? COUNT_W'($urandom())
                                            : COUNT_W'(phase_count[p]));
      if (p == GAPLESS_PHASE) begin
        hold_requests++;
      end
      sent = 0;
      while (sent < phase_items[p]) begin
        burst = $urandom_range(12, 1);
        for (int b = 0; b < burst && sent < phase_items[p]; b++) begin
          make_random_word(phase_alloc[p], phase_old[p], cmd, has_old, sector);
          send_word(cmd, has_old, sector, 1'b0, '{ST_DONE, '0});
          sent++;
          if (p == PAUSE_PHASE && sent == PAUSE_AT) begin
            wait_drained();
          end
        end
        if (p != GAPLESS_PHASE) begin
          sender_idle($urandom_range(6, 0));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    holds_served = 0;
    hold_left    = 0;
    mode_left    = 0;
    rx_mode      = RX_ALWAYS;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      rsp_if.ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(3, 0));
        mode_left = $urandom_range(80, 16);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: rsp_if.ready = 1'b1;
        RX_HALF:   rsp_if.ready = ($urandom_range(1, 0) == 0);
        RX_SPARSE: rsp_if.ready = ($urandom_range(3, 0) == 0);
        default:   rsp_if.ready = ($urandom_range(3, 0) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    rsp_word_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: status %0d alloc_sector %0d",
               rsp_if.status, rsp_if.alloc_sector);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.alloc_sector !== want.alloc_sector) begin
          $error("alloc_sector mismatch: expected %0d actual %0d",
                 want.alloc_sector, rsp_if.alloc_sector);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
